// ----- design/qvo_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad vertex order package
// Shared widths, corner types and the corner pair list.
// ----------------------------------------------------------------------------
package qvo_pkg;

    localparam int COORD_BITS  = 16;
    localparam int PATCH_BITS  = COORD_BITS + 1;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int PROD_BITS   = 2 * DIFF_BITS;
    localparam int CROSS_BITS  = PROD_BITS + 1;
    localparam int SQ_BITS     = 2 * COORD_BITS + 1;
    localparam int ROOT_W      = 2 * PATCH_BITS;
    localparam int IN_FIELDS_W = 8 * COORD_BITS;
    localparam int IN_W        = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 8 * COORD_BITS + 2 * PATCH_BITS;
    localparam int OUT_W       = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int NPAIRS      = 6;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic [1:0]                   idx_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } corner_t;

    typedef corner_t [3:0] quad_t;

    // Unordered corner pairs (a, b) with a < b.
    localparam idx_t PAIR_A [NPAIRS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam idx_t PAIR_B [NPAIRS] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

endpackage

// ----- design/quad_vertex_order_and_size.sv -----
`timescale 1ns / 1ps
// Stages: 10 ordering stages, then one stage per bit of the 17-bit square root.
// Throughput: one item per cycle; the whole pipeline advances whenever the
// output register is empty or being taken.
// Reset: rst_n clears all valid bits asynchronously; data registers are not reset.
// ----------------------------------------------------------------------------
// Quad vertex order and size
// Orders the four corners of a box and gives patch width and height.
// ----------------------------------------------------------------------------
module quad_vertex_order_and_size (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // point_x0, point_y0, point_x1, point_y1, point_x2, point_y2, point_x3, point_y3
    input  logic [qvo_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // sorted_x0, sorted_y0, .. sorted_x3, sorted_y3, patch_width, patch_height, zero pad
    output logic [qvo_pkg::OUT_W-1:0]   m_axis_tdata
);
    import qvo_pkg::*;

    logic  en;
    quad_t in_quad, ord_quad;
    logic  ord_valid;
    logic [SQ_BITS-1:0]    hi, lo;
    logic [PATCH_BITS-1:0] width_root, height_root;

    quad_t                 q_reg [PATCH_BITS];
    logic [PATCH_BITS-1:0] v_reg;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            in_quad[i].x = s_axis_tdata[2*i*COORD_BITS +: COORD_BITS];
            in_quad[i].y = s_axis_tdata[(2*i+1)*COORD_BITS +: COORD_BITS];
        end
    end

    qvo_order u_order (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_quad   (in_quad),
        .out_valid (ord_valid),
        .out_quad  (ord_quad),
        .out_hi    (hi),
        .out_lo    (lo)
    );

    qvo_isqrt u_sqrt_width (
        .clk      (clk),
        .en       (en),
        .radicand (hi),
        .root     (width_root)
    );

    qvo_isqrt u_sqrt_height (
        .clk      (clk),
        .en       (en),
        .radicand (lo),
        .root     (height_root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[PATCH_BITS-2:0], ord_valid};
        end
    end

    // Corners ride alongside the square root stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg[0] <= ord_quad;
            for (int s = 1; s < PATCH_BITS; s++)
            begin
                q_reg[s] <= q_reg[s-1];
            end
        end
    end

    assign m_axis_tvalid = v_reg[PATCH_BITS-1];

    always_comb
    begin
        m_axis_tdata = '0;
        for (int i = 0; i < 4; i++)
        begin
            m_axis_tdata[2*i*COORD_BITS +: COORD_BITS]     = q_reg[PATCH_BITS-1][i].x;
            m_axis_tdata[(2*i+1)*COORD_BITS +: COORD_BITS] = q_reg[PATCH_BITS-1][i].y;
        end
        m_axis_tdata[8*COORD_BITS +: PATCH_BITS]              = width_root;
        m_axis_tdata[8*COORD_BITS + PATCH_BITS +: PATCH_BITS] = height_root;
    end

endmodule

// ----- design/qvo_order.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad vertex order pipeline
// Ten register stages: pivot, differences, products, ordering matrix,
// stable insertion sort, rotation to the top-left corner and edge lengths.
// ----------------------------------------------------------------------------
module qvo_order (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  qvo_pkg::quad_t                in_quad,
    output logic                          out_valid,
    output qvo_pkg::quad_t                out_quad,
    output logic [qvo_pkg::SQ_BITS-1:0]   out_hi,
    output logic [qvo_pkg::SQ_BITS-1:0]   out_lo
);
    import qvo_pkg::*;

    localparam int NSTAGES = 10;

    logic [NSTAGES-1:0] v_reg;

    quad_t q1_reg, q2_reg, q3_reg, q4_reg, q5_reg, q6_reg;
    quad_t q7_reg, q8_reg, q9_reg, q10_reg;

    corner_t piv_next, tl_next, piv2_reg, tl2_reg;

    diff_t dx_next [4], dy_next [4], tdx_next [4], tdy_next [4];
    logic [3:0] same_next;
    diff_t dx3_reg [4], dy3_reg [4], tdx3_reg [4], tdy3_reg [4];
    logic [3:0] same3_reg;

    logic signed [PROD_BITS-1:0] pa_next [NPAIRS], pb_next [NPAIRS];
    logic signed [PROD_BITS-1:0] pa4_reg [NPAIRS], pb4_reg [NPAIRS];
    logic [2*COORD_BITS-1:0] tsx_next [4], tsy_next [4];
    logic [2*COORD_BITS-1:0] tsx4_reg [4], tsy4_reg [4];
    logic [3:0] same4_reg;

    logic [3:0][3:0] bf_next, bf5_reg;
    logic [SQ_BITS-1:0] tld_next [4], tld5_reg [4], tld6_reg [4];

    idx_t ord_next [4], ord6_reg [4];

    quad_t rot_next;
    diff_t ed_next [4], ed8_reg [4];
    logic [2*COORD_BITS-1:0] esq_next [4], esq9_reg [4];
    logic [SQ_BITS-1:0] hi_next, lo_next, hi10_reg, lo10_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NSTAGES-2:0], in_valid};
        end
    end

    // Pivot and bounding-box top-left.
    always_comb
    begin
        piv_next = q1_reg[0];
        tl_next  = q1_reg[0];
        for (int i = 1; i < 4; i++)
        begin
            if (q1_reg[i].y < piv_next.y ||
                (q1_reg[i].y == piv_next.y && q1_reg[i].x < piv_next.x))
            begin
                piv_next = q1_reg[i];
            end
            if (q1_reg[i].x < tl_next.x)
            begin
                tl_next.x = q1_reg[i].x;
            end
            if (q1_reg[i].y < tl_next.y)
            begin
                tl_next.y = q1_reg[i].y;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            dx_next[i]   = diff_t'(q2_reg[i].x) - diff_t'(piv2_reg.x);
            dy_next[i]   = diff_t'(q2_reg[i].y) - diff_t'(piv2_reg.y);
            tdx_next[i]  = diff_t'(q2_reg[i].x) - diff_t'(tl2_reg.x);
            tdy_next[i]  = diff_t'(q2_reg[i].y) - diff_t'(tl2_reg.y);
            same_next[i] = (q2_reg[i] == piv2_reg);
        end
    end

    always_comb
    begin
        for (int p = 0; p < NPAIRS; p++)
        begin
            pa_next[p] = PROD_BITS'(dx3_reg[PAIR_A[p]] * dy3_reg[PAIR_B[p]]);
            pb_next[p] = PROD_BITS'(dy3_reg[PAIR_A[p]] * dx3_reg[PAIR_B[p]]);
        end
        for (int i = 0; i < 4; i++)
        begin
            tsx_next[i] = (2*COORD_BITS)'(tdx3_reg[i] * tdx3_reg[i]);
            tsy_next[i] = (2*COORD_BITS)'(tdy3_reg[i] * tdy3_reg[i]);
        end
    end

    // bf_next[a][b] is set when corner a must come before corner b.
    always_comb
    begin
        logic signed [CROSS_BITS-1:0] cr;
        idx_t ia, ib;
        bf_next = '0;
        cr = '0;
        ia = '0;
        ib = '0;
        for (int p = 0; p < NPAIRS; p++)
        begin
            ia = PAIR_A[p];
            ib = PAIR_B[p];
            cr = CROSS_BITS'(pa4_reg[p]) - CROSS_BITS'(pb4_reg[p]);
            if (same4_reg[ia] || same4_reg[ib])
            begin
                bf_next[ia][ib] = same4_reg[ia] && !same4_reg[ib];
                bf_next[ib][ia] = same4_reg[ib] && !same4_reg[ia];
            end
            else
            begin
                bf_next[ia][ib] = !cr[CROSS_BITS-1] && (cr != '0);
                bf_next[ib][ia] = cr[CROSS_BITS-1];
            end
        end
        for (int i = 0; i < 4; i++)
        begin
            tld_next[i] = SQ_BITS'(tsx4_reg[i]) + SQ_BITS'(tsy4_reg[i]);
        end
    end

    // Stable insertion sort over corner indices; each insertion stops at the
    // first neighbour it may not pass.
    always_comb
    begin
        idx_t k_idx;
        logic moving;
        k_idx  = '0;
        moving = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            ord_next[i] = idx_t'(i);
        end
        for (int i = 1; i < 4; i++)
        begin
            moving = 1'b1;
            for (int j = i; j > 0; j--)
            begin
                if (moving && bf5_reg[ord_next[j]][ord_next[j-1]])
                begin
                    k_idx         = ord_next[j];
                    ord_next[j]   = ord_next[j-1];
                    ord_next[j-1] = k_idx;
                end
                else
                begin
                    moving = 1'b0;
                end
            end
        end
    end

    // Earliest corner in sorted order nearest the top-left starts the output.
    always_comb
    begin
        logic [SQ_BITS-1:0] best;
        idx_t start;
        best  = tld6_reg[ord6_reg[0]];
        start = '0;
        for (int k = 1; k < 4; k++)
        begin
            if (tld6_reg[ord6_reg[k]] < best)
            begin
                best  = tld6_reg[ord6_reg[k]];
                start = idx_t'(k);
            end
        end
        for (int k = 0; k < 4; k++)
        begin
            rot_next[k] = q6_reg[ord6_reg[start + idx_t'(k)]];
        end
    end

    always_comb
    begin
        ed_next[0] = diff_t'(q7_reg[0].x) - diff_t'(q7_reg[1].x);
        ed_next[1] = diff_t'(q7_reg[0].y) - diff_t'(q7_reg[1].y);
        ed_next[2] = diff_t'(q7_reg[1].x) - diff_t'(q7_reg[2].x);
        ed_next[3] = diff_t'(q7_reg[1].y) - diff_t'(q7_reg[2].y);
        for (int i = 0; i < 4; i++)
        begin
            esq_next[i] = (2*COORD_BITS)'(ed8_reg[i] * ed8_reg[i]);
        end
    end

    always_comb
    begin
        logic [SQ_BITS-1:0] e0, e1;
        e0 = SQ_BITS'(esq9_reg[0]) + SQ_BITS'(esq9_reg[1]);
        e1 = SQ_BITS'(esq9_reg[2]) + SQ_BITS'(esq9_reg[3]);
        hi_next = (e0 > e1) ? e0 : e1;
        lo_next = (e0 > e1) ? e1 : e0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1_reg    <= in_quad;
            q2_reg    <= q1_reg;
            piv2_reg  <= piv_next;
            tl2_reg   <= tl_next;
            q3_reg    <= q2_reg;
            dx3_reg   <= dx_next;
            dy3_reg   <= dy_next;
            tdx3_reg  <= tdx_next;
            tdy3_reg  <= tdy_next;
            same3_reg <= same_next;
            q4_reg    <= q3_reg;
            pa4_reg   <= pa_next;
            pb4_reg   <= pb_next;
            tsx4_reg  <= tsx_next;
            tsy4_reg  <= tsy_next;
            same4_reg <= same3_reg;
            q5_reg    <= q4_reg;
            bf5_reg   <= bf_next;
            tld5_reg  <= tld_next;
            q6_reg    <= q5_reg;
            ord6_reg  <= ord_next;
            tld6_reg  <= tld5_reg;
            q7_reg    <= rot_next;
            q8_reg    <= q7_reg;
            ed8_reg   <= ed_next;
            q9_reg    <= q8_reg;
            esq9_reg  <= esq_next;
            q10_reg   <= q9_reg;
            hi10_reg  <= hi_next;
            lo10_reg  <= lo_next;
        end
    end

    assign out_valid = v_reg[NSTAGES-1];
    assign out_quad  = q10_reg;
    assign out_hi    = hi10_reg;
    assign out_lo    = lo10_reg;

endmodule

// ----- design/qvo_isqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad vertex order square root
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module qvo_isqrt (
    input  logic                            clk,
    input  logic                            en,
    input  logic [qvo_pkg::SQ_BITS-1:0]     radicand,
    output logic [qvo_pkg::PATCH_BITS-1:0]  root
);
    import qvo_pkg::*;

    logic [ROOT_W-1:0]     rem_reg  [PATCH_BITS];
    logic [PATCH_BITS-1:0] root_reg [PATCH_BITS];

    for (genvar s = 0; s < PATCH_BITS; s++)
    begin : g_stage
        localparam int B = PATCH_BITS - 1 - s;
        logic [ROOT_W-1:0]     rem_in;
        logic [ROOT_W-1:0]     trial;
        logic [PATCH_BITS-1:0] root_in;

        if (s == 0)
        begin : g_first
            assign rem_in  = ROOT_W'(radicand);
            assign root_in = '0;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
        end

        // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
        assign trial = (ROOT_W'(root_in) << (B + 1)) | (ROOT_W'(1) << (2 * B));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_in >= trial)
                begin
                    rem_reg[s]  <= rem_in - trial;
                    root_reg[s] <= root_in | (PATCH_BITS'(1) << B);
                end
                else
                begin
                    rem_reg[s]  <= rem_in;
                    root_reg[s] <= root_in;
                end
            end
        end
    end

    assign root = root_reg[PATCH_BITS-1];

endmodule

// ----- design/qvo_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad vertex order checker
// Port-level properties of the block, bound to the top level.
// ----------------------------------------------------------------------------
module qvo_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic [qvo_pkg::IN_W-1:0]   s_axis_tdata,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [qvo_pkg::OUT_W-1:0]  m_axis_tdata
);
    import qvo_pkg::*;

    logic [PATCH_BITS-1:0] w, h;
    assign w = m_axis_tdata[8*COORD_BITS +: PATCH_BITS];
    assign h = m_axis_tdata[8*COORD_BITS + PATCH_BITS +: PATCH_BITS];

    // The output holds while it is stalled.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");

    // Height comes from the shorter edge.
    a_height_le_width: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> h <= w)
        else $error("patch height exceeds patch width");

    // The input is only held off by a stalled output.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output back-pressure");

    // No output item while reset is applied.
    a_reset: assert property (@(posedge clk)
        !rst_n |-> !m_axis_tvalid)
        else $error("output valid during reset");

endmodule

bind quad_vertex_order_and_size qvo_checker u_qvo_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
